// ----- rtl/dpb_pkg.sv -----
// Package: widths, limits, register indexes and reset values of the depth back-projection block.
`default_nettype none
package dpb_pkg;

  localparam int ROW_W   = 9;
  localparam int COL_W   = 9;
  localparam int DEPTH_W = 15;
  localparam int CTR_W   = 16;
  localparam int GAIN_W  = 32;
  localparam int XY_W    = 32;
  localparam int Z_W     = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int ROW_LIMIT = 512;
  localparam int COL_LIMIT = 512;

  localparam int IDX_SHIFT = 4;
  localparam int XY_SHIFT  = 20;
  localparam int Z_SHIFT   = 16;

  localparam int MAG1_W = CTR_W + DEPTH_W;
  localparam int MAG2_W = MAG1_W + GAIN_W;
  localparam int PZ_W   = DEPTH_W + GAIN_W;

  localparam logic [CTR_W-1:0]  CENTER_ROW_RST = 16'd3392;
  localparam logic [CTR_W-1:0]  CENTER_COL_RST = 16'd4096;
  localparam logic [GAIN_W-1:0] ROW_GAIN_RST   = 32'd150616;
  localparam logic [GAIN_W-1:0] COL_GAIN_RST   = 32'd150616;
  localparam logic [GAIN_W-1:0] DEPTH_GAIN_RST = 32'd54975581;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_ROW = 3'd0,
    CFG_CENTER_COL = 3'd1,
    CFG_ROW_GAIN   = 3'd2,
    CFG_COL_GAIN   = 3'd3,
    CFG_DEPTH_GAIN = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [CTR_W-1:0]  center_row;
    logic [CTR_W-1:0]  center_col;
    logic [GAIN_W-1:0] row_gain;
    logic [GAIN_W-1:0] col_gain;
    logic [GAIN_W-1:0] depth_gain;
  } cfg_t;

endpackage
`default_nettype wire

// ----- rtl/dpb_pix_if.sv -----
// Interface: depth pixel input channel.
`default_nettype none
interface dpb_pix_if;
  import dpb_pkg::*;

  logic               valid;
  logic               ready;
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   col;
  logic [DEPTH_W-1:0] depth;

  modport source (output valid, output row, output col, output depth, input ready);
  modport sink   (input valid, input row, input col, input depth, output ready);
endinterface
`default_nettype wire

// ----- rtl/dpb_pnt_if.sv -----
// Interface: camera-space point output channel.
`default_nettype none
interface dpb_pnt_if;
  import dpb_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [XY_W-1:0] point_x;
  logic signed [XY_W-1:0] point_y;
  logic [Z_W-1:0]         point_z;
  logic                   point_valid;

  modport source (output valid, output point_x, output point_y, output point_z,
                  output point_valid, input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  input point_valid, output ready);
endinterface
`default_nettype wire

// ----- rtl/dpb_cfg_if.sv -----
// Interface: configuration register write channel.
`default_nettype none
interface dpb_cfg_if;
  import dpb_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/depth_pixel_backprojection.sv -----
// Top level: pinhole back-projection of depth pixels into camera-space points.
//
//  channel  | modport | payload                                  | ready
//  ---------+---------+------------------------------------------+-----------------
//  pix_i    | sink    | row[9] col[9] depth[15]                  | pipeline moves
//  pnt_o    | source  | point_x[32] point_y[32] point_z[31] flag | from consumer
//  cfg_i    | sink    | index[3] data[32]                        | always high
//
// One word per cycle sustained while pnt_o ready stays high; each word passes
// through the registered stages below, from input accept to output valid.
// Stages: offset subtract, depth multiply, gain multiply, round and saturate.
// Reset clears the stage valid bits and loads the register reset values.
// A stall holds the output word; empty stages behind it still take words.
`default_nettype none
module depth_pixel_backprojection (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dpb_pix_if.sink   pix_i,
  dpb_pnt_if.source pnt_o,
  dpb_cfg_if.sink   cfg_i
);
  import dpb_pkg::*;

  cfg_t cfg;

  dpb_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  dpb_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .pix_i  (pix_i),
    .pnt_o  (pnt_o)
  );
endmodule
`default_nettype wire

// ----- rtl/dpb_cfg_regs.sv -----
// Configuration register file: principal point and gains.
`default_nettype none
module dpb_cfg_regs (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dpb_cfg_if.sink     cfg_i,
  output dpb_pkg::cfg_t cfg_o
);
  import dpb_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_CENTER_ROW: cfg_d.center_row = cfg_i.data[CTR_W-1:0];
        CFG_CENTER_COL: cfg_d.center_col = cfg_i.data[CTR_W-1:0];
        CFG_ROW_GAIN:   cfg_d.row_gain   = cfg_i.data[GAIN_W-1:0];
        CFG_COL_GAIN:   cfg_d.col_gain   = cfg_i.data[GAIN_W-1:0];
        CFG_DEPTH_GAIN: cfg_d.depth_gain = cfg_i.data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_row <= CENTER_ROW_RST;
      cfg_q.center_col <= CENTER_COL_RST;
      cfg_q.row_gain   <= ROW_GAIN_RST;
      cfg_q.col_gain   <= COL_GAIN_RST;
      cfg_q.depth_gain <= DEPTH_GAIN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
endmodule
`default_nettype wire

// ----- rtl/dpb_datapath.sv -----
// Four-stage back-projection pipeline: offset, depth multiply, gain multiply, round/saturate.
`default_nettype none
module dpb_datapath (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire dpb_pkg::cfg_t cfg_i,
  dpb_pix_if.sink            pix_i,
  dpb_pnt_if.source          pnt_o
);
  import dpb_pkg::*;

  function automatic logic [XY_W-1:0] sat_axis(input logic [MAG2_W-1:0] mag,
                                               input logic neg);
    logic [MAG2_W:0]          s;
    logic [MAG2_W-XY_SHIFT:0] r;
    logic [MAG2_W-XY_SHIFT:0] pos_max;
    logic [MAG2_W-XY_SHIFT:0] neg_max;
    pos_max = (MAG2_W-XY_SHIFT+1)'({1'b0, {(XY_W-1){1'b1}}});
    neg_max = (MAG2_W-XY_SHIFT+1)'({1'b1, {(XY_W-1){1'b0}}});
    s = {1'b0, mag} + ((MAG2_W+1)'(1) << (XY_SHIFT-1));
    r = (MAG2_W-XY_SHIFT+1)'(s >> XY_SHIFT);
    if (neg) begin
      if (r > neg_max) r = neg_max;
      sat_axis = XY_W'(~r + (MAG2_W-XY_SHIFT+1)'(1));
    end else begin
      if (r > pos_max) r = pos_max;
      sat_axis = XY_W'(r);
    end
  endfunction

  // stage enables, back to front
  logic en1, en2, en3, en4;
  logic v1_q, v2_q, v3_q, v4_q;

  assign en4 = !v4_q || pnt_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign pix_i.ready = en1;

  // stage 1: offsets from principal point
  logic [CTR_W-1:0]   pos_x, pos_y, diff_x_d, diff_y_d;
  logic               neg_x_d, neg_y_d, in_range;
  logic [DEPTH_W-1:0] depth_d;
  logic [CTR_W-1:0]   diff_x1_q, diff_y1_q;
  logic               neg_x1_q, neg_y1_q;
  logic [DEPTH_W-1:0] depth1_q;

  always_comb begin
    pos_x    = CTR_W'(pix_i.row) << IDX_SHIFT;
    pos_y    = CTR_W'(pix_i.col) << IDX_SHIFT;
    neg_x_d  = cfg_i.center_row > pos_x;
    neg_y_d  = cfg_i.center_col > pos_y;
    diff_x_d = neg_x_d ? cfg_i.center_row - pos_x : pos_x - cfg_i.center_row;
    diff_y_d = neg_y_d ? cfg_i.center_col - pos_y : pos_y - cfg_i.center_col;
    in_range = (int'(pix_i.row) < ROW_LIMIT) && (int'(pix_i.col) < COL_LIMIT);
    // out of range: zero depth forces an all-zero result
    depth_d  = in_range ? pix_i.depth : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en1 && pix_i.valid) begin
      diff_x1_q <= diff_x_d;
      diff_y1_q <= diff_y_d;
      neg_x1_q  <= neg_x_d;
      neg_y1_q  <= neg_y_d;
      depth1_q  <= depth_d;
    end
  end

  // stage 2: offset times depth, depth times depth gain
  logic [MAG1_W-1:0] mag_x2_q, mag_y2_q;
  logic [PZ_W-1:0]   pz2_q;
  logic              neg_x2_q, neg_y2_q, nz2_q;

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      mag_x2_q <= MAG1_W'(diff_x1_q) * MAG1_W'(depth1_q);
      mag_y2_q <= MAG1_W'(diff_y1_q) * MAG1_W'(depth1_q);
      pz2_q    <= PZ_W'(depth1_q) * PZ_W'(cfg_i.depth_gain);
      neg_x2_q <= neg_x1_q;
      neg_y2_q <= neg_y1_q;
      nz2_q    <= depth1_q != '0;
    end
  end

  // stage 3: axis gain multiply, Z round and clamp
  logic [MAG2_W-1:0] mag_x3_q, mag_y3_q;
  logic [Z_W-1:0]    z3_q;
  logic              neg_x3_q, neg_y3_q, nz3_q;
  logic [PZ_W:0]     z_sum;
  logic [XY_W-1:0]   z_rnd;
  logic [Z_W-1:0]    z_d;

  always_comb begin
    z_sum = {1'b0, pz2_q} + ((PZ_W+1)'(1) << (Z_SHIFT-1));
    z_rnd = XY_W'(z_sum >> Z_SHIFT);
    z_d   = z_rnd[XY_W-1] ? {Z_W{1'b1}} : z_rnd[Z_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      mag_x3_q <= MAG2_W'(mag_x2_q) * MAG2_W'(cfg_i.row_gain);
      mag_y3_q <= MAG2_W'(mag_y2_q) * MAG2_W'(cfg_i.col_gain);
      z3_q     <= z_d;
      neg_x3_q <= neg_x2_q;
      neg_y3_q <= neg_y2_q;
      nz3_q    <= nz2_q;
    end
  end

  // stage 4: X/Y round, clamp, sign; output register
  logic [XY_W-1:0] x4_q, y4_q;
  logic [Z_W-1:0]  z4_q;
  logic            nz4_q;

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      x4_q  <= sat_axis(mag_x3_q, neg_x3_q);
      y4_q  <= sat_axis(mag_y3_q, neg_y3_q);
      z4_q  <= z3_q;
      nz4_q <= nz3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= pix_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  assign pnt_o.valid       = v4_q;
  assign pnt_o.point_x     = $signed(x4_q);
  assign pnt_o.point_y     = $signed(y4_q);
  assign pnt_o.point_z     = z4_q;
  assign pnt_o.point_valid = nz4_q;
endmodule
`default_nettype wire

// ----- rtl/dpb_checker.sv -----
// Port-level checker for the back-projection block, with its bind.
`default_nettype none
module dpb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        pix_valid_i,
  input wire logic        pix_ready_i,
  input wire logic        pnt_valid_i,
  input wire logic        pnt_ready_i,
  input wire logic [31:0] point_x_i,
  input wire logic [31:0] point_y_i,
  input wire logic [30:0] point_z_i,
  input wire logic        point_valid_i
);

  // stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pnt_valid_i && !pnt_ready_i |=> pnt_valid_i && $stable(point_x_i) &&
      $stable(point_y_i) && $stable(point_z_i) && $stable(point_valid_i))
    else $error("stalled output word changed");

  // no measurement means an all-zero point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pnt_valid_i && !point_valid_i |-> point_x_i == '0 && point_y_i == '0 &&
      point_z_i == '0)
    else $error("invalid point with nonzero coordinates");

  // with the consumer ready while it passes the stages, an accepted word reaches the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i && pix_ready_i ##1 pnt_ready_i ##1 pnt_ready_i ##1 pnt_ready_i
      |=> pnt_valid_i)
    else $error("accepted word not delivered on time");

  // a free output stage never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pnt_valid_i |-> pix_ready_i)
    else $error("input blocked with empty output stage");

endmodule

bind depth_pixel_backprojection dpb_checker u_dpb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .pix_valid_i   (pix_i.valid),
  .pix_ready_i   (pix_i.ready),
  .pnt_valid_i   (pnt_o.valid),
  .pnt_ready_i   (pnt_o.ready),
  .point_x_i     (pnt_o.point_x),
  .point_y_i     (pnt_o.point_y),
  .point_z_i     (pnt_o.point_z),
  .point_valid_i (pnt_o.point_valid)
);
`default_nettype wire

// ----- tb/depth_pixel_backprojection_chk.sv -----
// Checker: predicts camera-space points from accepted depth pixels and compares each output word.
`default_nettype none
module depth_pixel_backprojection_chk (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dpb_pix_if        pix_i,
  dpb_pnt_if        pnt_i,
  dpb_cfg_if        cfg_i,
  output int        errors_o,
  output int        pending_o,
  output int        checked_o
);
  import dpb_pkg::*;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [Z_W-1:0]         z;
    logic                   flag;
  } point_t;

  localparam logic [63:0] POS_MAX = 64'd2147483647;
  localparam logic [63:0] NEG_MAX = 64'd2147483648;

  cfg_t   regs;
  point_t point_q[$];

  // (idx*16 - center) * depth * gain, magnitude rounded at Q.20, clamped
  function automatic logic [XY_W-1:0] axis_coord(input int unsigned idx,
                                                 input logic [CTR_W-1:0] center,
                                                 input logic [DEPTH_W-1:0] depth,
                                                 input logic [GAIN_W-1:0] gain);
    logic [63:0] pos;
    logic [63:0] mag;
    logic [63:0] r;
    logic        neg;
    pos = 64'(idx) << IDX_SHIFT;
    neg = 64'(center) > pos;
    mag = neg ? 64'(center) - pos : pos - 64'(center);
    mag = mag * 64'(depth) * 64'(gain);
    r = (mag + (64'd1 << (XY_SHIFT - 1))) >> XY_SHIFT;
    if (neg) begin
      if (r > NEG_MAX) r = NEG_MAX;
      return XY_W'(64'd0 - r);
    end
    if (r > POS_MAX) r = POS_MAX;
    return XY_W'(r);
  endfunction

  function automatic point_t project_pixel(input logic [ROW_W-1:0] row,
                                           input logic [COL_W-1:0] col,
                                           input logic [DEPTH_W-1:0] depth);
    point_t      p;
    logic [63:0] z;
    p = '0;
    if (int'(row) >= ROW_LIMIT || int'(col) >= COL_LIMIT) return p;
    z = (64'(depth) * 64'(regs.depth_gain) + (64'd1 << (Z_SHIFT - 1))) >> Z_SHIFT;
    if (z > POS_MAX) z = POS_MAX;
    p.x    = axis_coord(32'(row), regs.center_row, depth, regs.row_gain);
    p.y    = axis_coord(32'(col), regs.center_col, depth, regs.col_gain);
    p.z    = Z_W'(z);
    p.flag = depth != '0;
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    point_t want;
    if (!rst_ni) begin
      regs = '{center_row: CENTER_ROW_RST, center_col: CENTER_COL_RST,
               row_gain: ROW_GAIN_RST, col_gain: COL_GAIN_RST,
               depth_gain: DEPTH_GAIN_RST};
      point_q.delete();
    end else begin
      if (pnt_i.valid && pnt_i.ready) begin
        if (point_q.size() == 0) begin
          $display("%0t: point word with no pixel outstanding", $time);
          errors_o++;
        end else begin
          want = point_q.pop_front();
          checked_o++;
          if (pnt_i.point_x !== want.x) begin
            $display("%0t: point_x expected %h actual %h", $time, want.x, pnt_i.point_x);
            errors_o++;
          end
          if (pnt_i.point_y !== want.y) begin
            $display("%0t: point_y expected %h actual %h", $time, want.y, pnt_i.point_y);
            errors_o++;
          end
          if (pnt_i.point_z !== want.z) begin
            $display("%0t: point_z expected %h actual %h", $time, want.z, pnt_i.point_z);
            errors_o++;
          end
          if (pnt_i.point_valid !== want.flag) begin
            $display("%0t: point_valid expected %b actual %b", $time, want.flag,
                     pnt_i.point_valid);
            errors_o++;
          end
        end
      end
      if (pix_i.valid && pix_i.ready)
        point_q.insert(point_q.size(), project_pixel(pix_i.row, pix_i.col, pix_i.depth));
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_CENTER_ROW: regs.center_row = cfg_i.data[CTR_W-1:0];
          CFG_CENTER_COL: regs.center_col = cfg_i.data[CTR_W-1:0];
          CFG_ROW_GAIN:   regs.row_gain   = cfg_i.data[GAIN_W-1:0];
          CFG_COL_GAIN:   regs.col_gain   = cfg_i.data[GAIN_W-1:0];
          CFG_DEPTH_GAIN: regs.depth_gain = cfg_i.data[GAIN_W-1:0];
          default: ;
        endcase
      end
    end
    pending_o = point_q.size();
  end

endmodule
`default_nettype wire

// ----- tb/depth_pixel_backprojection_tb.sv -----
// Testbench top: drives pixels, register writes and output backpressure, and reports the verdict.
`default_nettype none
module depth_pixel_backprojection_tb;
  import dpb_pkg::*;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 175;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 16;
  localparam int LIMIT_CYCLES    = 400000;
  localparam int NUM_REGS        = CFG_DEPTH_GAIN + 1;

  typedef enum int {PACE_FULL, PACE_RANDOM, PACE_SPARSE} pace_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  dpb_pix_if pix();
  dpb_pnt_if pnt();
  dpb_cfg_if cfg();

  int    errors;
  int    pending;
  int    checked;
  int    cycles      = 0;
  int    sent        = 0;
  int    hold_asked  = 0;
  int    hold_served = 0;
  pace_e tx_pace     = PACE_FULL;
  pace_e rx_pace     = PACE_FULL;

  depth_pixel_backprojection DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .pnt_o  (pnt),
    .cfg_i  (cfg)
  );

  depth_pixel_backprojection_chk u_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (pix),
    .pnt_i     (pnt),
    .cfg_i     (cfg),
    .errors_o  (errors),
    .pending_o (pending),
    .checked_o (checked)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d points still outstanding", $time, pending);
      $display("depth_pixel_backprojection_tb: done, errors");
      $finish;
    end
  end

  function automatic int draw_gap(input pace_e pace);
    case (pace)
      PACE_FULL:   return 0;
      PACE_RANDOM: return $urandom_range(0, 16);
      default:     return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
    endcase
  endfunction

  // output side: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    bit seen;
    pnt.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_asked != hold_served) begin
        gap = HOLD_CYCLES;
        hold_served++;
      end else begin
        gap = draw_gap(rx_pace);
      end
      if (gap > 0) begin
        pnt.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pnt.ready <= 1'b1;
      do begin
        @(negedge clk_i);
        seen = pnt.valid;
        @(posedge clk_i);
      end while (!seen);
    end
  end

  task automatic send_pixel(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                            input logic [DEPTH_W-1:0] depth);
    int gap;
    bit seen;
    gap = draw_gap(tx_pace);
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.row   <= row;
    pix.col   <= col;
    pix.depth <= depth;
    do begin
      @(negedge clk_i);
      seen = pix.ready;
      @(posedge clk_i);
    end while (!seen);
    sent++;
  endtask

  task automatic send_random_pixel();
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [DEPTH_W-1:0] depth;
    row   = ROW_W'($urandom);
    col   = COL_W'($urandom);
    depth = DEPTH_W'($urandom);
    case ($urandom_range(0, 7))
      0: row = $urandom_range(0, 1) ? '1 : '0;
      1: col = $urandom_range(0, 1) ? '1 : '0;
      2: case ($urandom_range(0, 2))
           0:       depth = '0;
           1:       depth = DEPTH_W'(1);
           default: depth = '1;
         endcase
      3: depth = depth >> $urandom_range(1, DEPTH_W - 1);
      default: ;
    endcase
    send_pixel(row, col, depth);
  endtask

  // leaves valid high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    bit seen;
    cfg.valid <= 1'b1;
    cfg.index <= index;
    cfg.data  <= data;
    do begin
      @(negedge clk_i);
      seen = cfg.ready;
      @(posedge clk_i);
    end while (!seen);
  endtask

  task automatic program_phase(input int phase);
    logic [CFG_DATA_W-1:0] word [NUM_REGS];
    int k;
    for (k = 0; k < NUM_REGS; k++) word[k] = $urandom >> $urandom_range(0, 31);
    case (phase)
      1: for (k = 0; k < NUM_REGS; k++) word[k] = '0;
      2: for (k = 0; k < NUM_REGS; k++) word[k] = '1;
      3: begin
        word[CFG_CENTER_ROW] = '0;
        word[CFG_CENTER_COL] = '0;
        word[CFG_ROW_GAIN]   = '1;
        word[CFG_COL_GAIN]   = '1;
        word[CFG_DEPTH_GAIN] = '1;
      end
      default: ;
    endcase
    for (k = 0; k < NUM_REGS; k++) write_reg(CFG_IDX_W'(k), word[k]);
    // unused index, must leave every register alone
    write_reg(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, NUM_REGS)), $urandom);
    cfg.valid <= 1'b0;
  endtask

  task automatic drain();
    pix.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int phase;
    pix.valid = 1'b0;
    pix.row   = '0;
    pix.col   = '0;
    pix.depth = '0;
    cfg.valid = 1'b0;
    cfg.index = CFG_CENTER_ROW;
    cfg.data  = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) program_phase(phase);
      tx_pace = pace_e'($urandom_range(0, 2));
      rx_pace = pace_e'($urandom_range(0, 2));
      if (phase == 3) begin
        tx_pace = PACE_FULL;
        rx_pace = PACE_FULL;
      end
      if (phase == 4) begin
        tx_pace = PACE_FULL;
        hold_asked++;
      end
      if (phase == 0) begin
        send_pixel('0, '0, '0);
        send_pixel('1, '1, '1);
        send_pixel('0, '0, '1);
        send_pixel('1, '1, 15'd1);
        send_pixel('0, '1, '1);
        send_pixel('1, '0, '1);
        // pixel exactly on the principal point
        send_pixel(9'd212, 9'd256, '1);
        send_pixel(9'd212, 9'd256, 15'd1);
        send_pixel(9'd211, 9'd257, '1);
        send_pixel(9'd1, 9'd1, 15'd1);
        send_pixel(9'd255, 9'd255, 15'h4000);
        send_pixel(9'h155, 9'h0AA, 15'h5555);
        send_pixel(9'h0AA, 9'h155, 15'h2AAA);
        send_pixel(9'd100, 9'd400, '0);
      end
      repeat (ITEMS_PER_PHASE) send_random_pixel();
      drain();
    end

    $display("%0d pixels over %0d register settings, %0d points checked, %0d mismatches",
             sent, PHASES, checked, errors);
    $display("covered zero depth, saturation both ways, long output hold-off and idle gaps");
    if (errors == 0 && pending == 0) begin
      $display("depth_pixel_backprojection_tb: done, clean");
    end else begin
      $display("depth_pixel_backprojection_tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
rtl/dpb_pkg.sv
rtl/dpb_pix_if.sv
rtl/dpb_pnt_if.sv
rtl/dpb_cfg_if.sv
rtl/dpb_cfg_regs.sv
rtl/dpb_datapath.sv
rtl/depth_pixel_backprojection.sv
rtl/dpb_checker.sv
tb/depth_pixel_backprojection_chk.sv
tb/depth_pixel_backprojection_tb.sv
